/* src/rgb_to_hls_convert_defines.svh */
// Assertion macros used by the checker file of the RGB to HLS converter.
`ifndef RGB_TO_HLS_CONVERT_DEFINES_SVH
`define RGB_TO_HLS_CONVERT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define RGBHLS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbhls assertion failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define RGBHLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbhls assertion failed");

`endif

/* src/rgbhls_pkg.sv */
// Package with the fixed constants and types of the RGB to HLS converter.
package rgbhls_pkg;

  localparam int HUE_W     = 11;
  localparam int HUE_TURN  = 1440;
  localparam int HUE_SIXTH = 240;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } hue_sect_t;

endpackage

/* src/rgbhls_ifs.sv */
// Valid/ready channel interfaces for RGB pixels and HLS results.
interface rgbhls_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhls_hls_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                       valid;
  logic                       ready;
  logic [rgbhls_pkg::HUE_W-1:0] hue;
  logic [CHANNEL_BITS-1:0]    lightness;
  logic [CHANNEL_BITS-1:0]    saturation;

  modport source (output valid, output hue, output lightness, output saturation,
                  input ready);
  modport sink   (input valid, input hue, input lightness, input saturation,
                  output ready);
endinterface

/* src/rgb_to_hls_convert.sv */
// Top level of the pipelined RGB to HLS pixel converter.
// Pixels arrive on in_pix (red, green, blue) and results leave on out_hls
// (hue in quarter degrees, lightness, saturation); each channel moves a request
// when valid and ready are both high at a rising edge of clk.
// One pixel can be taken in every cycle while out_hls is not stalled, and one
// result is given per pixel, in order. Q = max(CHANNEL_BITS + 1, 9) is the
// number of divider stages. Three front stages find the extremes, the sums and
// the dividends, Q stages each produce one quotient bit of both saturation and
// hue, and a last stage adds the sector offset, wraps the hue and saturates.
// The whole pipeline advances together: when out_hls.ready is low while a
// result is shown, every stage holds and in_pix.ready falls, so nothing is
// dropped or repeated. Empty stages advance freely while the output is free.
// A synchronous active-low reset on rst_n clears all valid bits; the block
// needs no warm-up and can take a pixel as soon as reset is released.
module rgb_to_hls_convert #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  rgbhls_pix_if.sink    in_pix,
  rgbhls_hls_if.source  out_hls
);
  import rgbhls_pkg::*;

  localparam int CB  = CHANNEL_BITS;
  localparam int QW  = (CB + 1 > 9) ? CB + 1 : 9;
  localparam int SXW = 2 * CB + 1;
  localparam int HXW = CB + 10;
  localparam int XW  = (SXW > HXW) ? SXW : HXW;
  localparam int CW  = XW + QW;
  localparam int TW  = 12;

  localparam logic [CB-1:0] FULL     = '1;
  localparam logic [CB:0]   TWO_FULL = {FULL, 1'b0};

  logic adv;

  // Stage 1: extremes and the sector that holds the maximum.
  logic [CB-1:0] mx, mn, ha, hb;
  hue_sect_t     sect;
  logic          s1_valid_r;
  logic [CB-1:0] s1_max_r, s1_min_r, s1_ha_r, s1_hb_r;
  hue_sect_t     s1_sect_r;

  always_comb begin
    mx   = in_pix.red;
    mn   = in_pix.red;
    sect = SECT_RED;
    if (in_pix.green < mn) begin
      mn = in_pix.green;
    end else if (in_pix.green > mx) begin
      mx   = in_pix.green;
      sect = SECT_GREEN;
    end
    if (in_pix.blue < mn) begin
      mn = in_pix.blue;
    end else if (in_pix.blue > mx) begin
      mx   = in_pix.blue;
      sect = SECT_BLUE;
    end
    case (sect)
      SECT_GREEN: begin
        ha = in_pix.blue;
        hb = in_pix.red;
      end
      SECT_BLUE: begin
        ha = in_pix.red;
        hb = in_pix.green;
      end
      default: begin
        ha = in_pix.green;
        hb = in_pix.blue;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_pix.valid;
    end
    if (adv) begin
      s1_max_r  <= mx;
      s1_min_r  <= mn;
      s1_ha_r   <= ha;
      s1_hb_r   <= hb;
      s1_sect_r <= sect;
    end
  end

  // Stage 2: sum, spread, hue offset and saturation divisor.
  logic [CB:0]   sum, delta, mirror;
  logic [CB-1:0] diff, den;
  logic          s2_valid_r;
  logic [CB:0]   s2_sum_r, s2_delta_r;
  logic [CB-1:0] s2_diff_r, s2_den_r;
  hue_sect_t     s2_sect_r;

  always_comb begin
    sum    = {1'b0, s1_max_r} + {1'b0, s1_min_r};
    diff   = s1_max_r - s1_min_r;
    delta  = {1'b0, s1_ha_r} + {1'b0, diff} - {1'b0, s1_hb_r};
    mirror = TWO_FULL - sum;
    den    = (sum <= {1'b0, FULL}) ? sum[CB-1:0] : mirror[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (adv) begin
      s2_sum_r   <= sum;
      s2_delta_r <= delta;
      s2_diff_r  <= diff;
      s2_den_r   <= den;
      s2_sect_r  <= s1_sect_r;
    end
  end

  // Stage 3 feeds the divider; index 0 of the divider arrays is this stage.
  logic [CB+1:0] sum_rnd;
  logic [SXW-1:0] xs;
  logic [HXW-1:0] xh;

  logic          dv_valid_r [0:QW];
  hue_sect_t     dv_sect_r  [0:QW];
  logic [CB-1:0] dv_light_r [0:QW];
  logic          dv_grey_r  [0:QW];
  logic [CB:0]   dv_ys_r    [0:QW];
  logic [CB:0]   dv_yh_r    [0:QW];
  logic [XW-1:0] dv_srem_r  [0:QW];
  logic [XW-1:0] dv_hrem_r  [0:QW];
  logic [QW-1:0] dv_sq_r    [0:QW];
  logic [QW-1:0] dv_hq_r    [0:QW];

  always_comb begin
    sum_rnd = {1'b0, s2_sum_r} + {{(CB + 1){1'b0}}, 1'b1};
    xs = (SXW'(s2_diff_r) << (CB + 1)) - (SXW'(s2_diff_r) << 1) + SXW'(s2_den_r);
    xh = (HXW'(s2_delta_r) << 9) - (HXW'(s2_delta_r) << 5) + HXW'(s2_diff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= s2_valid_r;
    end
    if (adv) begin
      dv_sect_r[0]  <= s2_sect_r;
      dv_light_r[0] <= sum_rnd[CB:1];
      dv_grey_r[0]  <= (s2_diff_r == '0);
      dv_ys_r[0]    <= {s2_den_r, 1'b0};
      dv_yh_r[0]    <= {s2_diff_r, 1'b0};
      dv_srem_r[0]  <= XW'(xs);
      dv_hrem_r[0]  <= XW'(xh);
      dv_sq_r[0]    <= '0;
      dv_hq_r[0]    <= '0;
    end
  end

  // Divider stages: each one settles one quotient bit of both divisions.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int SH = QW - k;
    logic [CW-1:0] s_trial, h_trial;
    logic          s_ge, h_ge;

    always_comb begin
      s_trial = CW'(dv_ys_r[k-1]) << SH;
      h_trial = CW'(dv_yh_r[k-1]) << SH;
      s_ge    = CW'(dv_srem_r[k-1]) >= s_trial;
      h_ge    = CW'(dv_hrem_r[k-1]) >= h_trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[k] <= dv_valid_r[k-1];
      end
      if (adv) begin
        dv_sect_r[k]  <= dv_sect_r[k-1];
        dv_light_r[k] <= dv_light_r[k-1];
        dv_grey_r[k]  <= dv_grey_r[k-1];
        dv_ys_r[k]    <= dv_ys_r[k-1];
        dv_yh_r[k]    <= dv_yh_r[k-1];
        dv_srem_r[k]  <= s_ge ? dv_srem_r[k-1] - s_trial[XW-1:0] : dv_srem_r[k-1];
        dv_hrem_r[k]  <= h_ge ? dv_hrem_r[k-1] - h_trial[XW-1:0] : dv_hrem_r[k-1];
        dv_sq_r[k]    <= dv_sq_r[k-1] | (QW'(s_ge) << SH);
        dv_hq_r[k]    <= dv_hq_r[k-1] | (QW'(h_ge) << SH);
      end
    end
  end

  // Output stage: sector offset, wrap of the hue, clamp of the saturation.
  logic [TW-1:0]    base, hsum;
  logic [HUE_W-1:0] hue_nxt;
  logic [CB-1:0]    sat_nxt;
  logic             out_valid_r;
  logic [HUE_W-1:0] out_hue_r;
  logic [CB-1:0]    out_light_r, out_sat_r;

  always_comb begin
    case (dv_sect_r[QW])
      SECT_GREEN: base = TW'(2 * HUE_SIXTH);
      SECT_BLUE:  base = TW'(4 * HUE_SIXTH);
      default:    base = '0;
    endcase
    hsum = base + TW'(HUE_TURN - HUE_SIXTH) + TW'(dv_hq_r[QW][8:0]);
    if (hsum >= TW'(HUE_TURN)) begin
      hsum = hsum - TW'(HUE_TURN);
    end
    sat_nxt = (dv_sq_r[QW] > QW'(FULL)) ? FULL : dv_sq_r[QW][CB-1:0];
    hue_nxt = hsum[HUE_W-1:0];
    if (dv_grey_r[QW]) begin
      sat_nxt = '0;
      hue_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[QW];
    end
    if (adv) begin
      out_hue_r   <= hue_nxt;
      out_light_r <= dv_light_r[QW];
      out_sat_r   <= sat_nxt;
    end
  end

  assign adv               = !out_valid_r || out_hls.ready;
  assign in_pix.ready      = adv;
  assign out_hls.valid     = out_valid_r;
  assign out_hls.hue       = out_hue_r;
  assign out_hls.lightness = out_light_r;
  assign out_hls.saturation = out_sat_r;

endmodule

/* src/rgbhls_checker.sv */
// Port-level checker for the RGB to HLS converter and its bind statement.
`include "rgb_to_hls_convert_defines.svh"

module rgbhls_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rgbhls_pkg::HUE_W-1:0] hue,
  input logic [CHANNEL_BITS-1:0]      saturation
);
  import rgbhls_pkg::*;

  `RGBHLS_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
  `RGBHLS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(hue) && $stable(saturation))
  `RGBHLS_ASSERT_IMPLY(a_hue_range, out_valid, hue < HUE_W'(HUE_TURN))
  `RGBHLS_ASSERT_IMPLY(a_grey_hue, out_valid && saturation == '0, hue == '0)
  `RGBHLS_ASSERT_IMPLY(a_free_accepts, !out_valid, in_ready)

endmodule

bind rgb_to_hls_convert rgbhls_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_rgbhls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_pix.ready),
  .out_valid  (out_hls.valid),
  .out_ready  (out_hls.ready),
  .hue        (out_hls.hue),
  .saturation (out_hls.saturation)
);
